/* rtl/osi_pkg.sv */
// Package for the obstacle speed interlock: widths, request and reason codes,
// configuration register indexes, reset values and shared types.
// No dependencies.
package osi_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int AGE_WIDTH_DEF   = 16;

    localparam int KIND_W     = 3;
    localparam int REASON_W   = 3;
    localparam int VEL_W      = 16;
    localparam int RNG_W      = 16;
    localparam int RAD_W      = 12;
    localparam int SPD_W      = 15;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 2 * VEL_W;

    // R + 2C and R + C, and their squares
    localparam int RN_W    = RAD_W + 2;
    localparam int RS_W    = RAD_W + 1;
    localparam int RN_SQ_W = 2 * RN_W;
    localparam int RS_SQ_W = 2 * RS_W;

    localparam logic [RAD_W-1:0]  RST_BASE_RADIUS = RAD_W'(250);
    localparam logic [RAD_W-1:0]  RST_CLEAR_DIST  = RAD_W'(300);
    localparam logic [RNG_W-1:0]  RST_SONAR_CLEAR = RNG_W'(300);
    localparam logic [SPD_W-1:0]  RST_SLOW_SPEED  = SPD_W'(200);
    localparam logic [TICK_W-1:0] RST_STALE_TICKS = TICK_W'(1000);

    typedef enum logic [KIND_W-1:0] {
        REQ_TWIST       = 3'd0,
        REQ_COST_START  = 3'd1,
        REQ_COST_POINT  = 3'd2,
        REQ_SONAR_START = 3'd3,
        REQ_SONAR_RANGE = 3'd4,
        REQ_TICK        = 3'd5
    } req_t;

    typedef enum logic [REASON_W-1:0] {
        REASON_PASS        = 3'd0,
        REASON_MAP_STALE   = 3'd1,
        REASON_OBST_SLOW   = 3'd2,
        REASON_OBST_STOP   = 3'd3,
        REASON_SONAR_STALE = 3'd4,
        REASON_SONAR_STOP  = 3'd5
    } reason_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE       = 3'd0,
        CFG_BASE_RADIUS  = 3'd1,
        CFG_CLEAR_DIST   = 3'd2,
        CFG_SONAR_CLEAR  = 3'd3,
        CFG_SLOW_SPEED   = 3'd4,
        CFG_STALE_TICKS  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic x_ahead;
        logic y_inside;
    } pt_flags_t;

endpackage

/* rtl/osi_geom.sv */
// Point geometry stage: absolute values and squares of a costmap point,
// registered, plus the ahead and lateral-inside flags.
// Depends on osi_pkg.
module osi_geom
    import osi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic        [RAD_W-1:0]       radius,
    output logic        [2*COORD_WIDTH-1:0] x_sq,
    output logic        [2*COORD_WIDTH-1:0] y_sq,
    output pt_flags_t                     flags
);

    localparam int SQ_W = 2 * COORD_WIDTH;
    localparam int YR_W = (COORD_WIDTH > RAD_W) ? COORD_WIDTH : RAD_W;

    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic [SQ_W-1:0]        x_sq_reg;
    logic [SQ_W-1:0]        x_sq_next;
    logic [SQ_W-1:0]        y_sq_reg;
    logic [SQ_W-1:0]        y_sq_next;
    pt_flags_t              flags_reg;
    pt_flags_t              flags_next;

    always_comb
    begin
        ax = point_x[COORD_WIDTH-1] ? COORD_WIDTH'(-point_x) : COORD_WIDTH'(point_x);
        ay = point_y[COORD_WIDTH-1] ? COORD_WIDTH'(-point_y) : COORD_WIDTH'(point_y);
        x_sq_next = SQ_W'(ax) * SQ_W'(ax);
        y_sq_next = SQ_W'(ay) * SQ_W'(ay);
        flags_next.x_ahead  = !point_x[COORD_WIDTH-1] && (point_x != '0);
        flags_next.y_inside = YR_W'(ay) < YR_W'(radius);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_sq_reg  <= x_sq_next;
            y_sq_reg  <= y_sq_next;
            flags_reg <= flags_next;
        end
    end

    assign x_sq  = x_sq_reg;
    assign y_sq  = y_sq_reg;
    assign flags = flags_reg;

endmodule

/* rtl/obstacle_speed_interlock.sv */
// Obstacle speed interlock, top level: config registers, input stage,
// geometry stage, obstacle/sonar state and the result register.
// Depends on osi_pkg and osi_geom.
//
// Usage: one input stream (s_*) carries six word kinds in s_tuser: twist,
// costmap start, costmap point, sonar start, sonar range and tick. Only a
// twist word gives a result, and only while enable is set; it leaves on the
// output stream (m_*) with the limited linear speed, the unchanged angular
// speed and the limit reason. Every other word only updates the obstacle
// flags and the age counters and vanishes in the pipe.
// Throughput is one word per cycle; s_tready stays high while the pipe moves.
// A word passes the input register, the squaring register of the point
// geometry unit, then the result register, where flags and ages update in
// word order, so a twist sees every earlier point, range and tick.
// Configuration is written through cfg_we/cfg_idx/cfg_data while the block is
// idle, a user rule the block does not enforce; writing enable to zero clears
// the three obstacle flags. Reset clears the pipe, loads the default register
// values and marks map and sonar data stale (ages all ones). There is no
// clearing pass. When the receiver holds m_tready low the result word holds,
// and the two stages behind it still fill before s_tready drops.
module obstacle_speed_interlock
    import osi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int AGE_WIDTH   = AGE_WIDTH_DEF,
    parameter int IN_DATA_W   = ((3 * VEL_W + 2 * COORD_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // lin_vel, ang_vel, point_x, point_y, sonar_range, unused fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // lin_out, ang_out
    output logic [OUT_DATA_W-1:0] m_tdata,
    // limit_reason
    output logic [REASON_W-1:0]   m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PX_LSB = 2 * VEL_W;
    localparam int PY_LSB = PX_LSB + COORD_WIDTH;
    localparam int RG_LSB = PY_LSB + COORD_WIDTH;
    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int D2_W   = SQ_W + 1;
    localparam int TH_W   = (D2_W > RN_SQ_W) ? D2_W : RN_SQ_W;
    localparam int AC_W   = (AGE_WIDTH > TICK_W) ? AGE_WIDTH : TICK_W;

    // configuration
    logic              enable_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic [RAD_W-1:0]  clear_dist_reg;
    logic [RNG_W-1:0]  sonar_clear_reg;
    logic [SPD_W-1:0]  slow_speed_reg;
    logic [TICK_W-1:0] stale_ticks_reg;
    logic [RN_SQ_W-1:0] rn_sq_reg;
    logic [RS_SQ_W-1:0] rs_sq_reg;
    logic [RN_W-1:0]   rn;
    logic [RS_W-1:0]   rs;

    // input stage
    logic                          v1_reg;
    req_t                          kind1_reg;
    logic signed [VEL_W-1:0]       lin1_reg;
    logic signed [VEL_W-1:0]       ang1_reg;
    logic signed [COORD_WIDTH-1:0] px1_reg;
    logic signed [COORD_WIDTH-1:0] py1_reg;
    logic [RNG_W-1:0]              rng1_reg;

    // geometry stage
    logic                    v2_reg;
    req_t                    kind2_reg;
    logic signed [VEL_W-1:0] lin2_reg;
    logic signed [VEL_W-1:0] ang2_reg;
    logic [RNG_W-1:0]        rng2_reg;
    logic [SQ_W-1:0]         x_sq;
    logic [SQ_W-1:0]         y_sq;
    pt_flags_t               pt_flags;

    // result register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [VEL_W-1:0]        lin_out_reg;
    logic [VEL_W-1:0]        lin_out_next;
    logic [VEL_W-1:0]        ang_out_reg;
    reason_t                 reason_reg;
    reason_t                 reason_next;

    // interlock state
    logic                 near_reg;
    logic                 near_next;
    logic                 stop_reg;
    logic                 stop_next;
    logic                 sonar_block_reg;
    logic                 sonar_block_next;
    logic [AGE_WIDTH-1:0] map_age_reg;
    logic [AGE_WIDTH-1:0] map_age_next;
    logic [AGE_WIDTH-1:0] sonar_age_reg;
    logic [AGE_WIDTH-1:0] sonar_age_next;

    logic            rdy1;
    logic            rdy2;
    logic            rdy3;
    logic            move12;
    logic            move23;
    logic [D2_W-1:0] d2;
    logic            near_hit;
    logic            stop_hit;
    logic            map_stale;
    logic            sonar_stale;

    assign rdy3     = !out_valid_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign move12   = v1_reg && rdy2;
    assign move23   = v2_reg && rdy3;

    assign rn = RN_W'(radius_reg) + RN_W'({clear_dist_reg, 1'b0});
    assign rs = RS_W'(radius_reg) + RS_W'(clear_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            radius_reg      <= RST_BASE_RADIUS;
            clear_dist_reg  <= RST_CLEAR_DIST;
            sonar_clear_reg <= RST_SONAR_CLEAR;
            slow_speed_reg  <= RST_SLOW_SPEED;
            stale_ticks_reg <= RST_STALE_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_ENABLE:      enable_reg      <= cfg_data[0];
                CFG_BASE_RADIUS: radius_reg      <= cfg_data[RAD_W-1:0];
                CFG_CLEAR_DIST:  clear_dist_reg  <= cfg_data[RAD_W-1:0];
                CFG_SONAR_CLEAR: sonar_clear_reg <= cfg_data[RNG_W-1:0];
                CFG_SLOW_SPEED:  slow_speed_reg  <= cfg_data[SPD_W-1:0];
                CFG_STALE_TICKS: stale_ticks_reg <= cfg_data[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rn_sq_reg <= RN_SQ_W'(rn) * RN_SQ_W'(rn);
        rs_sq_reg <= RS_SQ_W'(rs) * RS_SQ_W'(rs);
    end

    // pipe valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && rdy1)
        begin
            kind1_reg <= req_t'(s_tuser);
            lin1_reg  <= s_tdata[VEL_W-1:0];
            ang1_reg  <= s_tdata[2*VEL_W-1:VEL_W];
            px1_reg   <= s_tdata[PX_LSB +: COORD_WIDTH];
            py1_reg   <= s_tdata[PY_LSB +: COORD_WIDTH];
            rng1_reg  <= s_tdata[RG_LSB +: RNG_W];
        end
        if (move12)
        begin
            kind2_reg <= kind1_reg;
            lin2_reg  <= lin1_reg;
            ang2_reg  <= ang1_reg;
            rng2_reg  <= rng1_reg;
        end
        if (move23)
        begin
            lin_out_reg <= lin_out_next;
            ang_out_reg <= ang2_reg;
            reason_reg  <= reason_next;
        end
    end

    osi_geom #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_geom (
        .clk         (clk),
        .load        (move12),
        .point_x     (px1_reg),
        .point_y     (py1_reg),
        .radius      (radius_reg),
        .x_sq        (x_sq),
        .y_sq        (y_sq),
        .flags       (pt_flags)
    );

    always_comb
    begin
        d2        = D2_W'(x_sq) + D2_W'(y_sq);
        near_hit  = pt_flags.x_ahead && (TH_W'(d2) < TH_W'(rn_sq_reg));
        stop_hit  = pt_flags.x_ahead && pt_flags.y_inside &&
                    (TH_W'(d2) < TH_W'(rs_sq_reg));
        map_stale   = (map_age_reg == '1) ||
                      (AC_W'(map_age_reg) > AC_W'(stale_ticks_reg));
        sonar_stale = (sonar_age_reg == '1) ||
                      (AC_W'(sonar_age_reg) > AC_W'(stale_ticks_reg));
    end

    // state update and twist limiting, in word order
    always_comb
    begin
        near_next        = near_reg;
        stop_next        = stop_reg;
        sonar_block_next = sonar_block_reg;
        map_age_next     = map_age_reg;
        sonar_age_next   = sonar_age_reg;
        out_valid_next   = 1'b0;
        lin_out_next     = lin2_reg;
        reason_next      = REASON_PASS;

        if (!lin2_reg[VEL_W-1] && (lin2_reg != '0))
        begin
            if (map_stale)
            begin
                lin_out_next = '0;
                reason_next  = REASON_MAP_STALE;
            end
            else if (near_reg && stop_reg)
            begin
                lin_out_next = '0;
                reason_next  = REASON_OBST_STOP;
            end
            else if (near_reg)
            begin
                lin_out_next = VEL_W'(slow_speed_reg);
                reason_next  = REASON_OBST_SLOW;
            end
        end
        else if (lin2_reg[VEL_W-1])
        begin
            if (sonar_stale)
            begin
                lin_out_next = '0;
                reason_next  = REASON_SONAR_STALE;
            end
            else if (sonar_block_reg)
            begin
                lin_out_next = '0;
                reason_next  = REASON_SONAR_STOP;
            end
        end

        if (v2_reg)
        begin
            case (kind2_reg)
                REQ_TWIST:
                    out_valid_next = enable_reg;
                REQ_COST_START:
                begin
                    near_next = 1'b0;
                    stop_next = 1'b0;
                    if (enable_reg)
                        map_age_next = '0;
                end
                REQ_COST_POINT:
                begin
                    if (enable_reg)
                    begin
                        near_next = near_reg || near_hit;
                        stop_next = stop_reg || stop_hit;
                    end
                end
                REQ_SONAR_START:
                begin
                    sonar_block_next = 1'b0;
                    if (enable_reg)
                        sonar_age_next = '0;
                end
                REQ_SONAR_RANGE:
                begin
                    if (enable_reg && (rng2_reg < sonar_clear_reg))
                        sonar_block_next = 1'b1;
                end
                REQ_TICK:
                begin
                    if (map_age_reg != '1)
                        map_age_next = AGE_WIDTH'(map_age_reg + 1'b1);
                    if (sonar_age_reg != '1)
                        sonar_age_next = AGE_WIDTH'(sonar_age_reg + 1'b1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg        <= 1'b0;
            stop_reg        <= 1'b0;
            sonar_block_reg <= 1'b0;
            map_age_reg     <= '1;
            sonar_age_reg   <= '1;
        end
        else if (cfg_we && (cfg_idx == CFG_ENABLE) && !cfg_data[0])
        begin
            near_reg        <= 1'b0;
            stop_reg        <= 1'b0;
            sonar_block_reg <= 1'b0;
        end
        else if (move23)
        begin
            near_reg        <= near_next;
            stop_reg        <= stop_next;
            sonar_block_reg <= sonar_block_next;
            map_age_reg     <= map_age_next;
            sonar_age_reg   <= sonar_age_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {ang_out_reg, lin_out_reg};
    assign m_tuser  = reason_reg;

endmodule

/* rtl/osi_checker.sv */
// Port checker for the obstacle speed interlock, bound to the top level.
// Depends on osi_pkg and obstacle_speed_interlock.
module osi_checker
    import osi_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [REASON_W-1:0]   m_tuser
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // drop linear speed on every stop reason
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == REASON_MAP_STALE || m_tuser == REASON_OBST_STOP ||
                     m_tuser == REASON_SONAR_STALE || m_tuser == REASON_SONAR_STOP)
        |-> m_tdata[VEL_W-1:0] == '0)
        else $error("stop reason with nonzero linear speed");

    // slow speed is never reverse
    a_slow_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == REASON_OBST_SLOW) |-> !m_tdata[VEL_W-1])
        else $error("slow reason with reverse speed");

    // no result word right after a reset cycle
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind obstacle_speed_interlock osi_checker u_osi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/sv/tb_obstacle_speed_interlock.sv */
`timescale 1ns / 1ps
// Testbench for obstacle_speed_interlock: drives twist, costmap, sonar and tick words
// through the input stream and checks limited twists against a scoreboard predictor.
// Depends on osi_pkg and the obstacle_speed_interlock RTL.
module tb_obstacle_speed_interlock;
    import osi_pkg::*;

    localparam int DATA_W = ((3 * VEL_W + 2 * COORD_WIDTH_DEF + 7) / 8) * 8;
    localparam int LIMIT  = 300000;
    localparam int PHASE_WORDS = 75;

    typedef struct {
        logic [15:0] lin;
        logic [15:0] ang;
        reason_t     why;
    } limited_twist_t;

    class interlock_scoreboard;
        bit          en;
        logic [11:0] radius;
        logic [11:0] clear_dist;
        logic [15:0] sonar_thr;
        logic [14:0] slow_spd;
        logic [15:0] stale_lim;
        bit          near_f;
        bit          stop_f;
        bit          sonar_f;
        logic [15:0] map_age;
        logic [15:0] sonar_age;
        int          errors;
        limited_twist_t limited_q[$];

        function new();
            en         = 1'b0;
            radius     = RST_BASE_RADIUS;
            clear_dist = RST_CLEAR_DIST;
            sonar_thr  = RST_SONAR_CLEAR;
            slow_spd   = RST_SLOW_SPEED;
            stale_lim  = RST_STALE_TICKS;
            near_f     = 1'b0;
            stop_f     = 1'b0;
            sonar_f    = 1'b0;
            map_age    = 16'hFFFF;
            sonar_age  = 16'hFFFF;
            errors     = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(cfg_idx_t idx, logic [15:0] v);
            case (idx)
                CFG_ENABLE:
                begin
                    en = v[0];
                    if (!en)
                    begin
                        near_f  = 1'b0;
                        stop_f  = 1'b0;
                        sonar_f = 1'b0;
                    end
                end
                CFG_BASE_RADIUS: radius = v[11:0];
                CFG_CLEAR_DIST:  clear_dist = v[11:0];
                CFG_SONAR_CLEAR: sonar_thr = v;
                CFG_SLOW_SPEED:  slow_spd = v[14:0];
                CFG_STALE_TICKS: stale_lim = v;
                default: ;
            endcase
        endfunction

        function bit aged_out(logic [15:0] age);
            return age == 16'hFFFF || age > stale_lim;
        endfunction

        function logic [15:0] age_step(logic [15:0] age);
            return (age == 16'hFFFF) ? age : age + 16'd1;
        endfunction

        function void note_word(logic [2:0] kind, logic [DATA_W-1:0] d);
            logic signed [15:0] lin;
            logic signed [15:0] px;
            logic signed [15:0] py;
            longint ax, ay, d2, rn, rs;
            limited_twist_t r;
            case (kind)
                REQ_TWIST:
                begin
                    if (!en)
                        return;
                    lin   = d[15:0];
                    r.lin = lin;
                    r.ang = d[31:16];
                    r.why = REASON_PASS;
                    if (lin > 0)
                    begin
                        if (aged_out(map_age))
                        begin
                            r.lin = '0;
                            r.why = REASON_MAP_STALE;
                        end
                        else if (near_f && stop_f)
                        begin
                            r.lin = '0;
                            r.why = REASON_OBST_STOP;
                        end
                        else if (near_f)
                        begin
                            r.lin = {1'b0, slow_spd};
                            r.why = REASON_OBST_SLOW;
                        end
                    end
                    else if (lin < 0)
                    begin
                        if (aged_out(sonar_age))
                        begin
                            r.lin = '0;
                            r.why = REASON_SONAR_STALE;
                        end
                        else if (sonar_f)
                        begin
                            r.lin = '0;
                            r.why = REASON_SONAR_STOP;
                        end
                    end
                    limited_q.push_back(r);
                end
                REQ_COST_START:
                begin
                    near_f = 1'b0;
                    stop_f = 1'b0;
                    if (en)
                        map_age = '0;
                end
                REQ_COST_POINT:
                begin
                    if (!en)
                        return;
                    px = d[47:32];
                    py = d[63:48];
                    if (px <= 0)
                        return;
                    ax = longint'(px);
                    ay = longint'(py);
                    if (ay < 0)
                        ay = -ay;
                    d2 = ax * ax + ay * ay;
                    rn = longint'(radius) + 2 * longint'(clear_dist);
                    rs = longint'(radius) + longint'(clear_dist);
                    if (d2 < rn * rn)
                        near_f = 1'b1;
                    if (d2 < rs * rs && ay < longint'(radius))
                        stop_f = 1'b1;
                end
                REQ_SONAR_START:
                begin
                    sonar_f = 1'b0;
                    if (en)
                        sonar_age = '0;
                end
                REQ_SONAR_RANGE:
                begin
                    if (en && d[79:64] < sonar_thr)
                        sonar_f = 1'b1;
                end
                REQ_TICK:
                begin
                    map_age   = age_step(map_age);
                    sonar_age = age_step(sonar_age);
                end
                default: ;
            endcase
        endfunction

        task check_result(logic [31:0] data, logic [2:0] why);
            limited_twist_t r;
            if (limited_q.size() == 0)
            begin
                report($sformatf("result 0x%08h reason %0d with no twist pending", data, why));
                return;
            end
            r = limited_q.pop_front();
            if (data[15:0] !== r.lin)
                report($sformatf("lin_out %0d, expected %0d",
                                 $signed(data[15:0]), $signed(r.lin)));
            if (data[31:16] !== r.ang)
                report($sformatf("ang_out %0d, expected %0d",
                                 $signed(data[31:16]), $signed(r.ang)));
            if (why !== r.why)
                report($sformatf("limit_reason %0d, expected %0d", why, r.why));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [REASON_W-1:0]   m_tuser;
    logic              cfg_we = 1'b0;
    cfg_idx_t          cfg_idx = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    interlock_scoreboard sb = new();
    int words_sent = 0;
    int burst_left = 0;
    int hold_left = 0;
    int cycles = 0;

    obstacle_speed_interlock DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // check results and hold them on a stall pattern of its own
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (hold_left > 0)
            hold_left--;
        else
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    m_tready <= 1'b1;
                    hold_left = $urandom_range(30, 150);
                end
                1, 2, 3:
                begin
                    m_tready <= 1'b0;
                    hold_left = $urandom_range(0, 7);
                end
                default:
                begin
                    m_tready <= 1'b1;
                    hold_left = $urandom_range(0, 12);
                end
            endcase
        end
    end

    function automatic logic [DATA_W-1:0] pack_word(logic [15:0] lin, logic [15:0] ang,
                                                    logic [15:0] px, logic [15:0] py,
                                                    logic [15:0] rng);
        return {rng, py, px, ang, lin};
    endfunction

    function automatic logic [DATA_W-1:0] rand_fill();
        return DATA_W'({$urandom, $urandom, $urandom});
    endfunction

    function automatic logic [DATA_W-1:0] make_point();
        int rn, span, x, y;
        logic [DATA_W-1:0] d;
        rn   = int'(sb.radius) + 2 * int'(sb.clear_dist);
        span = rn + 40;
        d    = rand_fill();
        case ($urandom_range(0, 9))
            0:
            begin
                x = int'($urandom_range(0, 65535)) - 32768;
                y = int'($urandom_range(0, 65535)) - 32768;
            end
            1:
            begin
                x = int'($urandom_range(1, span));
                y = int'(sb.radius) + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    y = -y;
            end
            2:
            begin
                x = rn + int'($urandom_range(0, 2)) - 1;
                y = 0;
            end
            default:
            begin
                x = int'($urandom_range(0, span)) - 20;
                y = int'($urandom_range(0, 2 * span)) - span;
            end
        endcase
        if (x > 32767)
            x = 32767;
        if (x < -32768)
            x = -32768;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        d[47:32] = x[15:0];
        d[63:48] = y[15:0];
        return d;
    endfunction

    function automatic logic [DATA_W-1:0] make_range();
        int r;
        logic [DATA_W-1:0] d;
        d = rand_fill();
        if ($urandom_range(0, 2) == 0)
            r = int'($urandom_range(0, 65535));
        else
            r = int'(sb.sonar_thr) + int'($urandom_range(0, 6)) - 3;
        if (r < 0)
            r = 0;
        if (r > 65535)
            r = 65535;
        d[79:64] = r[15:0];
        return d;
    endfunction

    function automatic logic [DATA_W-1:0] make_twist();
        logic [DATA_W-1:0] d;
        d = rand_fill();
        case ($urandom_range(0, 9))
            0: d[15:0] = '0;
            1: d[15:0] = $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
            default: ;
        endcase
        return d;
    endfunction

    task automatic send_word(input logic [2:0] kind, input logic [DATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(kind, data);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.limited_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_regs(input logic [15:0] v [6]);
        for (int i = 0; i < 6; i++)
            write_reg(cfg_idx_t'(i), v[i]);
        cfg_we <= 1'b0;
    endtask

    task automatic random_sequence();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            if ($urandom_range(0, 9) != 0)
                send_word(REQ_COST_START, rand_fill());
            n = $urandom_range(1, 8);
            repeat (n) send_word(REQ_COST_POINT, make_point());
        end
        else if (pick < 50)
        begin
            if ($urandom_range(0, 9) != 0)
                send_word(REQ_SONAR_START, rand_fill());
            n = $urandom_range(1, 6);
            repeat (n) send_word(REQ_SONAR_RANGE, make_range());
        end
        else if (pick < 65)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(REQ_TICK, rand_fill());
        end
        else if (pick < 92)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_word(REQ_TWIST, make_twist());
        end
        else
            send_word(3'($urandom_range(0, 7)), rand_fill());
    endtask

    initial
    begin
        logic [15:0] regs [6];
        int target;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(REQ_TWIST, pack_word(16'd100, 16'd7, '0, '0, '0));
        drain();
        regs = '{16'd1, 16'd250, 16'd300, 16'd300, 16'd200, 16'd3};
        load_regs(regs);

        send_word(REQ_TWIST, pack_word(16'd100, 16'd1, '0, '0, '0));
        send_word(REQ_TWIST, pack_word(-16'sd100, 16'd2, '0, '0, '0));
        send_word(REQ_TWIST, pack_word(16'd0, 16'h8000, '0, '0, '0));
        send_word(REQ_COST_START, '0);
        send_word(REQ_COST_POINT, pack_word('0, '0, 16'd0, 16'd0, '0));
        send_word(REQ_COST_POINT, pack_word('0, '0, 16'h8000, 16'd0, '0));
        send_word(REQ_COST_POINT, pack_word('0, '0, 16'h7FFF, 16'h8000, '0));
        send_word(REQ_TWIST, pack_word(16'h7FFF, 16'h7FFF, '0, '0, '0));
        send_word(REQ_COST_POINT, pack_word('0, '0, 16'd850, 16'd0, '0));
        send_word(REQ_TWIST, pack_word(16'd1, 16'd3, '0, '0, '0));
        send_word(REQ_COST_POINT, pack_word('0, '0, 16'd849, 16'd0, '0));
        send_word(REQ_TWIST, pack_word(16'd500, 16'd4, '0, '0, '0));
        send_word(REQ_COST_POINT, pack_word('0, '0, 16'd1, 16'd250, '0));
        send_word(REQ_TWIST, pack_word(16'd500, 16'd5, '0, '0, '0));
        send_word(REQ_COST_POINT, pack_word('0, '0, 16'd1, -16'sd249, '0));
        send_word(REQ_TWIST, pack_word(16'h7FFF, 16'hFFFF, '0, '0, '0));
        send_word(REQ_SONAR_START, '0);
        send_word(REQ_SONAR_RANGE, pack_word('0, '0, '0, '0, 16'd300));
        send_word(REQ_TWIST, pack_word(16'h8000, 16'd6, '0, '0, '0));
        send_word(REQ_SONAR_RANGE, pack_word('0, '0, '0, '0, 16'd299));
        send_word(REQ_TWIST, pack_word(16'hFFFF, 16'd8, '0, '0, '0));
        send_word(3'd6, '1);
        send_word(3'd7, '1);
        repeat (4) send_word(REQ_TICK, '0);
        send_word(REQ_TWIST, pack_word(16'd5, 16'd9, '0, '0, '0));
        send_word(REQ_TWIST, pack_word(-16'sd5, 16'd10, '0, '0, '0));
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: regs = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
                1: regs = '{16'd1, 16'd4095, 16'd4095, 16'hFFFF, 16'h7FFF, 16'hFFFF};
                2: regs = '{16'd0, 16'($urandom_range(0, 700)), 16'($urandom_range(0, 700)),
                            16'($urandom_range(0, 1500)), 16'($urandom_range(0, 32767)),
                            16'($urandom_range(1, 40))};
                3: regs = '{16'd1, 16'd250, 16'd300, 16'd300, 16'd200, 16'd8};
                default: regs = '{16'($urandom_range(0, 7) != 0),
                                  16'($urandom_range(0, 700)), 16'($urandom_range(0, 700)),
                                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 32767)),
                                  16'($urandom_range(1, 40))};
            endcase
            load_regs(regs);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                random_sequence();
            drain();
        end

        if (sb.limited_q.size() != 0)
            sb.report($sformatf("%0d limited twists never came out", sb.limited_q.size()));
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
